// File: hdl/sha256sh_pkg.sv
// ----------------------------------------------------------------------------
// sha256sh_pkg
// Shared types and constants of the SHA-256 stream hasher: round constants,
// initial hash values, sequencer states and the core control/status structs.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

  typedef logic [31:0] word_t;

  // eight chaining or working words, index 0 is a / h0
  typedef logic [0:7][31:0] hash_t;

  typedef logic [0:63][31:0] round_k_t;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_OUT
  } seq_state_e;

  // top level to compression core
  typedef struct packed {
    logic push;   // shift one word into the schedule line
    logic start;  // load working vars and run 64 rounds
  } core_ctl_t;

  // compression core to top level
  typedef struct packed {
    logic busy;   // rounds in progress
    logic done;   // working vars final, one-cycle pulse
  } core_sts_t;

  localparam logic [7:0] PadByte    = 8'h80;
  localparam word_t      MarkerWord = {PadByte, 24'h000000};

  localparam hash_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam round_k_t RoundK = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: hdl/sha256sh_if.sv
// ----------------------------------------------------------------------------
// sha256sh_if
// Valid/ready channels of the hasher: message word beats in, digest word
// beats out.
// ----------------------------------------------------------------------------
interface sha256sh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        is_last;
  logic        empty_message;

  modport source (
    output valid, data_word, valid_bytes, is_last, empty_message,
    input  ready
  );
  modport sink (
    input  valid, data_word, valid_bytes, is_last, empty_message,
    output ready
  );
endinterface

interface sha256sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        digest_done;

  modport source (
    output valid, digest_word, word_number, digest_done,
    input  ready
  );
  modport sink (
    input  valid, digest_word, word_number, digest_done,
    output ready
  );
endinterface

// File: hdl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 of a stream of big-endian message words, eight digest words out.
// ----------------------------------------------------------------------------
// Input channel in_i: one beat per 32-bit message word, first byte in bits
// 31..24. valid_bytes (1..4) counts the leading bytes of the last word only;
// empty_message with is_last hashes no bytes from that beat.
// Output channel out_o: eight beats per message, digest words 0..7, with
// digest_done on the eighth.
// Timing: a word that does not fill a block is pushed into the schedule line.
// The sixteenth word of a block starts the shared round unit, which runs the
// 64 rounds; the chaining add follows when the core reports done. After the
// last word the padding words go in at one per cycle, paused while a
// compression runs, with one or two compressions, then the digest is offered.
// in_i.ready is high only while the sequencer is idle; one message word is
// worked on at a time.
// Reset loads the initial hash values and clears the length and fill count.
// A stalled receiver holds the current digest word; nothing is dropped, and
// input stays blocked until the eighth word is taken.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sha256sh_in_if.sink           in_i,
  sha256sh_out_if.source        out_o
);
  import sha256sh_pkg::*;

  seq_state_e  state_q, state_d;
  hash_t       chain_q, chain_d;
  logic [3:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        marker_q, marker_d;  // 0x80 word still owed
  logic        pad_q, pad_d;        // padding in progress
  logic        len_q, len_d;        // high length word pushed
  logic        final_q, final_d;    // last block of the message pushed
  logic [2:0]  out_cnt_q, out_cnt_d;

  core_ctl_t   core_ctl;
  core_sts_t   core_sts;
  word_t       push_word;
  hash_t       wv;

  logic [2:0]  nbytes;
  word_t       pad_word;

  // byte count and padded form of a last word
  always_comb begin
    if (in_i.empty_message) begin
      nbytes = 3'd0;
    end else begin
      case (in_i.valid_bytes) inside
        3'd0:       nbytes = 3'd0;
        [3'd1:3'd4]: nbytes = in_i.valid_bytes;
        default:    nbytes = 3'd4;
      endcase
    end
    case (nbytes[1:0])
      2'd1:    pad_word = {in_i.data_word[31:24], PadByte, 16'h0000};
      2'd2:    pad_word = {in_i.data_word[31:16], PadByte, 8'h00};
      2'd3:    pad_word = {in_i.data_word[31:8], PadByte};
      default: pad_word = MarkerWord;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    chain_d   = chain_q;
    fill_d    = fill_q;
    bitlen_d  = bitlen_q;
    marker_d  = marker_q;
    pad_d     = pad_q;
    len_d     = len_q;
    final_d   = final_q;
    out_cnt_d = out_cnt_q;
    core_ctl  = '0;
    push_word = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          core_ctl.push = 1'b1;
          fill_d        = fill_q + 4'd1;
          if (!in_i.is_last) begin
            push_word = in_i.data_word;
            bitlen_d  = bitlen_q + 64'd32;
          end else begin
            pad_d    = 1'b1;
            bitlen_d = bitlen_q + {58'd0, nbytes, 3'b000};
            if (nbytes == 3'd4) begin
              push_word = in_i.data_word;
              marker_d  = 1'b1;
            end else begin
              push_word = pad_word;
            end
          end
          if (fill_q == 4'd15) begin
            core_ctl.start = 1'b1;
            state_d        = S_COMP;
          end else if (in_i.is_last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        core_ctl.push = 1'b1;
        fill_d        = fill_q + 4'd1;
        if (marker_q) begin
          push_word = MarkerWord;
          marker_d  = 1'b0;
        end else if (len_q) begin
          push_word = bitlen_q[31:0];
          final_d   = 1'b1;
        end else if (fill_q == 4'd14) begin
          push_word = bitlen_q[63:32];
          len_d     = 1'b1;
        end
        if (fill_q == 4'd15) begin
          core_ctl.start = 1'b1;
          state_d        = S_COMP;
        end
      end
      S_COMP: begin
        if (core_sts.done) begin
          for (int i = 0; i < 8; i++) begin
            chain_d[i] = chain_q[i] + wv[i];
          end
          if (final_q) begin
            out_cnt_d = '0;
            state_d   = S_OUT;
          end else if (pad_q) begin
            state_d = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          out_cnt_d = out_cnt_q + 3'd1;
          if (out_cnt_q == 3'd7) begin
            chain_d  = InitHash;
            fill_d   = '0;
            bitlen_d = '0;
            marker_d = 1'b0;
            pad_d    = 1'b0;
            len_d    = 1'b0;
            final_d  = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chain_q   <= InitHash;
      fill_q    <= '0;
      bitlen_q  <= '0;
      marker_q  <= 1'b0;
      pad_q     <= 1'b0;
      len_q     <= 1'b0;
      final_q   <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      chain_q   <= chain_d;
      fill_q    <= fill_d;
      bitlen_q  <= bitlen_d;
      marker_q  <= marker_d;
      pad_q     <= pad_d;
      len_q     <= len_d;
      final_q   <= final_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  sha256sh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (core_ctl),
    .push_word_i (push_word),
    .chain_i     (chain_q),
    .sts_o       (core_sts),
    .wv_o        (wv)
  );

  // channel drive
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = chain_q[out_cnt_q];
  assign out_o.word_number = out_cnt_q;
  assign out_o.digest_done = (out_cnt_q == 3'd7);

`ifndef SYNTH
  // input and output beats never overlap
  a_in_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while digest offered");

  // a compression starts exactly on the sixteenth word of a block
  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.start |-> core_ctl.push && fill_q == 4'd15)
    else $error("compression started on a partial block");

  // after the last digest beat the chain is back at the initial values
  a_chain_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.digest_done) |=>
      chain_q == InitHash && bitlen_q == 64'd0 && state_q == S_IDLE)
    else $error("hash state not reinitialized after digest");

  // the core reports done only while the sequencer waits for it
  a_done_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_sts.done |-> state_q == S_COMP)
    else $error("compression done outside compress state");
`endif

endmodule

// File: hdl/sha256sh_core.sv
// ----------------------------------------------------------------------------
// sha256sh_core
// SHA-256 compression core: a 16-word schedule shift line that also serves
// as the block buffer, and one round unit reused for all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sha256sh_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256sh_pkg::core_ctl_t ctl_i,
  input  sha256sh_pkg::word_t    push_word_i,
  input  sha256sh_pkg::hash_t    chain_i,
  output sha256sh_pkg::core_sts_t sts_o,
  output sha256sh_pkg::hash_t    wv_o
);
  import sha256sh_pkg::*;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [15:0][31:0] sched_q, sched_d;
  hash_t             wv_q, wv_d;
  logic [5:0]        round_q, round_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  word_t big0, big1, sm0, sm1, ch, maj, t1, t2, w_next;

  // round functions on the current working vars and schedule taps
  always_comb begin
    big1   = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
    ch     = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    t1     = wv_q[7] + big1 + ch + RoundK[round_q] + sched_q[0];
    big0   = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
    maj    = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t2     = big0 + maj;
    sm0    = rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3);
    sm1    = rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10);
    w_next = sched_q[0] + sm0 + sched_q[9] + sm1;
  end

  // next state of the schedule line, working vars and round counter
  always_comb begin
    sched_d = sched_q;
    wv_d    = wv_q;
    round_d = round_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (ctl_i.push) begin
      sched_d = {push_word_i, sched_q[15:1]};
    end
    if (ctl_i.start) begin
      wv_d    = chain_i;
      round_d = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      sched_d = {w_next, sched_q[15:1]};
      wv_d    = '{t1 + t2, wv_q[0], wv_q[1], wv_q[2],
                  wv_q[3] + t1, wv_q[4], wv_q[5], wv_q[6]};
      round_d = round_q + 6'd1;
      if (round_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      wv_q    <= '0;
    end else begin
      round_q <= round_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      wv_q    <= wv_d;
    end
  end

  // schedule line, written before it is read
  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign wv_o       = wv_q;

`ifndef SYNTH
  // a start is never issued over a running compression
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("start while rounds in progress");

  // the done pulse follows the last round
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(round_q) == 6'd63 && !busy_q)
    else $error("done without last round");

  // the round counter is back at zero when a block finishes
  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> round_q == 6'd0)
    else $error("round counter not wrapped");
`endif

endmodule

// File: sim/sha256_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_test
// Self-checking bench for the SHA-256 stream hasher. Messages go in as word
// beats with bursty valid; a bit-exact SHA-256 predictor in the bench builds
// the eight digest beats of each message, and every digest beat taken under
// a stalling receiver is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256sh_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned TimeoutCycles = 1_000_000;
  localparam int unsigned TargetBeats   = 270;
  localparam int unsigned MaxReports    = 10;

  typedef struct {
    word_t      digest_word;
    logic [2:0] word_number;
    logic       digest_done;
  } digest_beat_t;

  typedef enum logic [1:0] {
    RxSteady,
    RxChoppy,
    RxSparse
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sha256sh_in_if  in_bus ();
  sha256sh_out_if out_bus ();

  sha256_stream_hasher_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // running hash of the message in flight
  hash_t        chain_q;
  word_t        block_q [16];
  int unsigned  fill_q;
  logic [63:0]  bits_q;
  digest_beat_t pending_digest [$];

  int unsigned  mismatches;
  int unsigned  beats_sent;
  int unsigned  burst_left;
  int unsigned  rx_left;
  rx_mode_e     rx_mode;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // SHA-256 predictor
  // ---------------------------------------------------------------------------
  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of block_q into the chaining value
  function automatic void fold_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = block_q[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_q[0] = chain_q[0] + a; chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c; chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e; chain_q[5] = chain_q[5] + f;
    chain_q[6] = chain_q[6] + g; chain_q[7] = chain_q[7] + h;
  endfunction

  function automatic void take_word(word_t w);
    block_q[fill_q] = w;
    fill_q++;
    if (fill_q == 16) begin
      fold_block();
      fill_q = 0;
    end
  endfunction

  // update the running hash with one accepted beat, queue digest on the last
  function automatic void hash_beat(word_t word, logic [2:0] nbytes_in, logic last,
                                    logic empty);
    int unsigned nbytes;
    word_t       keep;
    if (!last) begin
      take_word(word);
      bits_q += 64'd32;
      return;
    end
    nbytes = empty ? 0 : ((nbytes_in > 3'd4) ? 4 : nbytes_in);
    if (nbytes == 4) begin
      take_word(word);
      bits_q += 64'd32;
      take_word(MarkerWord);
    end else begin
      keep = (nbytes == 0) ? '0 : ~(32'hffff_ffff >> (8 * nbytes));
      take_word((word & keep) | (MarkerWord >> (8 * nbytes)));
      bits_q += 64'(8 * nbytes);
    end
    // no room for the length field, pad out a block of its own
    if (fill_q > 14) begin
      block_q[15] = '0;
      fold_block();
      fill_q = 0;
    end
    while (fill_q < 14) begin
      block_q[fill_q] = '0;
      fill_q++;
    end
    block_q[14] = bits_q[63:32];
    block_q[15] = bits_q[31:0];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      pending_digest.push_back('{digest_word: chain_q[i], word_number: 3'(i),
                                 digest_done: (i == 7)});
    end
    chain_q = InitHash;
    fill_q  = 0;
    bits_q  = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // digest checker
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t digest mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_digest.size() == 0) begin
        note_mismatch("unexpected beat", '0, out_bus.digest_word);
      end else begin
        want = pending_digest.pop_front();
        if (out_bus.digest_word !== want.digest_word)
          note_mismatch("digest_word", want.digest_word, out_bus.digest_word);
        if (out_bus.word_number !== want.word_number)
          note_mismatch("word_number", 32'(want.word_number), 32'(out_bus.word_number));
        if (out_bus.digest_done !== want.digest_done)
          note_mismatch("digest_done", 32'(want.digest_done), 32'(out_bus.digest_done));
      end
    end
  end

  // receiver stalls, switching between steady, choppy and sparse stretches
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxSteady: out_bus.ready <= 1'b1;
      RxChoppy: out_bus.ready <= 1'($urandom_range(0, 1));
      default:  out_bus.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // one message word beat; called and returns at a falling edge
  task automatic send_word(word_t word, logic [2:0] nbytes, logic last, logic empty);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.data_word     <= word;
    in_bus.valid_bytes   <= nbytes;
    in_bus.is_last       <= last;
    in_bus.empty_message <= empty;
    do @(posedge clk_i); while (!in_bus.ready);
    hash_beat(word, nbytes, last, empty);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // hold input until every queued digest beat has come out
  task automatic drain_digests();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_digest.size() != 0) @(negedge clk_i);
  endtask

  // full-word body of random content
  task automatic send_body(int unsigned nwords);
    for (int i = 0; i < nwords; i++) begin
      send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // field extremes and the odd last-word encodings
  task automatic test_field_extremes();
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1);   // empty message
    send_word(32'h0000_0000, 3'd7, 1'b1, 1'b1);   // empty message, bytes count ignored
    send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b0);   // zero valid bytes
    // non-last words ignore valid_bytes and empty_message
    send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b0, 1'b1);
    send_word(32'h8000_0000, 3'd1, 1'b0, 1'b0);
    send_word(32'h0000_0001, 3'd7, 1'b1, 1'b0);   // more than four bytes, taken as four
    send_word(32'h6162_63ff, 3'd3, 1'b1, 1'b0);   // "abc", junk low byte dropped
    send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b0);
    send_word(32'h0000_ffff, 3'd2, 1'b1, 1'b0);
    send_word(32'h1234_5678, 3'd5, 1'b1, 1'b0);
    send_word(32'hdead_beef, 3'd6, 1'b1, 1'b0);
  endtask

  // lengths where the length field does or does not fit the final block
  task automatic test_padding_boundaries();
    for (int nfull = 13; nfull <= 15; nfull++) begin
      send_body(nfull);
      send_word(rand_word(), 3'd2, 1'b1, 1'b0);
      send_body(nfull);
      send_word(rand_word(), 3'd4, 1'b1, 1'b0);
    end
  endtask

  // random messages, mostly short, a few spanning several blocks
  task automatic test_random_messages(int unsigned target);
    int unsigned nfull;
    logic [2:0]  nbytes;
    bit          paused;
    paused = 1'b0;
    while (beats_sent < target) begin
      case ($urandom_range(0, 19))
        0:       nfull = $urandom_range(30, 40);
        1, 2, 3: nfull = $urandom_range(9, 20);
        default: nfull = $urandom_range(0, 8);
      endcase
      send_body(nfull);
      nbytes = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      send_word(rand_word(), nbytes, 1'b1, ($urandom_range(0, 9) == 0));
      if (!paused && beats_sent > target / 2) begin
        drain_digests();
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid         = 1'b0;
    in_bus.data_word     = '0;
    in_bus.valid_bytes   = '0;
    in_bus.is_last       = 1'b0;
    in_bus.empty_message = 1'b0;
    out_bus.ready        = 1'b0;
    chain_q    = InitHash;
    fill_q     = 0;
    bits_q     = '0;
    mismatches = 0;
    beats_sent = 0;
    burst_left = 0;
    rx_left    = 0;
    rx_mode    = RxSteady;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_padding_boundaries();
    test_random_messages(TargetBeats);

    drain_digests();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_digest.size() == 0) begin
      $display("[sha256_stream_hasher_unit] OK");
    end else begin
      $display("[sha256_stream_hasher_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("[sha256_stream_hasher_unit] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/sha256sh_pkg.sv
hdl/sha256sh_if.sv
hdl/sha256sh_core.sv
hdl/sha256_stream_hasher_unit.sv
sim/sha256_stream_hasher_unit_test.sv
